// ----- hw/rtl/som_pkg.sv -----
`default_nettype none
package som_pkg;

    // grid and vector limits
    localparam int MAX_SIDE  = 16;
    localparam int MAX_DIM   = 64;
    localparam int MAX_NODES = 256;
    localparam int NODE_W    = 8;
    localparam int ELEM_W    = 6;
    localparam int ADDR_W    = NODE_W + ELEM_W;

    // item modes
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_TRAIN = 2'd1;
    localparam logic [1:0] MODE_CLASS = 2'd2;

    // register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DIM    = 2'd2;

    // arithmetic constants
    localparam logic [63:0] DIST_LIMIT  = 64'h0001_86A0_0000_0000;
    localparam logic [58:0] RADIUS_NUM  = 59'd625000000000000;
    localparam logic [32:0] RADIUS_BASE = 33'd1000000;
    localparam logic [32:0] S_MAX       = 33'd25000000;
    localparam logic [16:0] RATE_BASE   = 17'd100000;
    localparam int          DIV_STEPS   = 33;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRD,
        ST_DW1,
        ST_DW2,
        ST_DCMP,
        ST_RPREP,
        ST_RCHK,
        ST_RDEC,
        ST_URD,
        ST_ULOAD,
        ST_UDIV,
        ST_UWR,
        ST_FIN
    } t_state;

    // effective map geometry
    typedef struct packed {
        logic [4:0] width;
        logic [4:0] height;
        logic [6:0] dim;
    } t_geom;

    // controller to datapath
    typedef struct packed {
        logic              w_load;
        logic              x_load;
        logic              rd_en;
        logic              rd_dist;
        logic [NODE_W-1:0] node;
        logic [ELEM_W-1:0] elem;
        logic [3:0]        col;
        logic [3:0]        row;
        logic              acc_clr;
        logic              best_init;
        logic              cmp;
        logic              cnt_clr;
        logic              cnt_inc;
        logic              rad_prep;
        logic              rad_chk;
        logic              upd_load;
        logic              div_step;
        logic              upd_wr;
        logic              step_inc;
        logic              out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_radius;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

// ----- hw/rtl/som_item_if.sv -----
`default_nettype none
interface som_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [7:0]         node_index;
    logic [5:0]         element_index;
    logic signed [31:0] value;
    logic               last;

    modport source (output valid, mode, node_index, element_index, value, last,
                    input ready);
    modport sink   (input valid, mode, node_index, element_index, value, last,
                    output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/som_result_if.sv -----
`default_nettype none
interface som_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] winner_index;
    logic [3:0] winner_col;
    logic [3:0] winner_row;
    logic [8:0] updated_count;

    modport source (output valid, winner_index, winner_col, winner_row, updated_count,
                    input ready);
    modport sink   (input valid, winner_index, winner_col, winner_row, updated_count,
                    output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/som_train_step_core.sv -----
// channel   dir  handshake       payload
// i_item    in   valid / ready   mode, node_index, element_index, value, last
// o_result  out  valid / ready   winner_index, winner_col, winner_row, updated_count
// apb       in   psel / penable  paddr, pwdata, prdata (map_width, map_height, vector_dim)
//
// load items and non-final vector elements are taken directly in the idle state.
// a final element starts the distance pass: per node, ST_DRD reads the elements
// through one read port of the weight memory, one element per read, then ST_DW1,
// ST_DW2 and ST_DCMP; training adds a setup state, ST_RCHK and ST_RDEC per node, plus
// ST_URD, ST_ULOAD, the 33-step divider and ST_UWR per element inside the radius.
// reset is synchronous active low; the weight and input stores are not cleared.
// a result waits in the output register; the next vector stalls only at its end.
`default_nettype none
module som_train_step_core (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    som_item_if.sink    i_item,
    som_result_if.source o_result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import som_pkg::*;

    logic [4:0] r_width;
    logic [4:0] r_height;
    logic [6:0] r_dim;
    t_geom      w_geom;
    t_cmd       w_cmd;
    t_stat      w_stat;
    logic [8:0] w_chk_idx;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 5'd16;
            r_height <= 5'd16;
            r_dim    <= 7'd64;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_WIDTH:  r_width  <= pwdata[4:0];
                REG_HEIGHT: r_height <= pwdata[4:0];
                REG_DIM:    r_dim    <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = {27'd0, r_width};
            REG_HEIGHT: prdata = {27'd0, r_height};
            REG_DIM:    prdata = {25'd0, r_dim};
            default:    prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    // clamp geometry to the supported range
    always_comb begin
        w_geom.width  = (r_width == 5'd0) ? 5'd1 :
                        (r_width > 5'(MAX_SIDE)) ? 5'(MAX_SIDE) : r_width;
        w_geom.height = (r_height == 5'd0) ? 5'd1 :
                        (r_height > 5'(MAX_SIDE)) ? 5'(MAX_SIDE) : r_height;
        w_geom.dim    = (r_dim == 7'd0) ? 7'd1 :
                        (r_dim > 7'(MAX_DIM)) ? 7'(MAX_DIM) : r_dim;
    end

    som_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .i_item_mode  (i_item.mode),
        .i_item_last  (i_item.last),
        .o_item_ready (i_item.ready),
        .i_geom       (w_geom),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd)
    );

    som_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_node_index    (i_item.node_index),
        .i_element_index (i_item.element_index),
        .i_value         (i_item.value),
        .o_stat          (w_stat),
        .i_out_ready     (o_result.ready),
        .o_out_valid     (o_result.valid),
        .o_winner_index  (o_result.winner_index),
        .o_winner_col    (o_result.winner_col),
        .o_winner_row    (o_result.winner_row),
        .o_updated_count (o_result.updated_count)
    );

    // winner position must match its linear index
    assign w_chk_idx = 9'({5'd0, o_result.winner_row} * {4'd0, w_geom.width})
                     + 9'(o_result.winner_col);

    a_idx_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (w_chk_idx == {1'b0, o_result.winner_index}))
        else $error("winner index does not match row and column");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.updated_count <= 9'(MAX_NODES)))
        else $error("updated count beyond node count");

    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready && i_item.last &&
         (i_item.mode == MODE_TRAIN || i_item.mode == MODE_CLASS)) |=> !i_item.ready)
        else $error("item taken during winner search");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready && i_item.mode == MODE_LOAD && !o_result.valid)
        |=> !o_result.valid)
        else $error("weight load produced a result");
endmodule
`default_nettype wire

// ----- hw/rtl/som_ram.sv -----
`default_nettype none
module som_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/som_ctrl.sv -----
`default_nettype none
module som_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_item_valid,
    input  wire logic [1:0]     i_item_mode,
    input  wire logic           i_item_last,
    output logic                o_item_ready,
    input  wire som_pkg::t_geom i_geom,
    input  wire som_pkg::t_stat i_stat,
    output som_pkg::t_cmd       o_cmd
);
    import som_pkg::*;

    t_state            r_state, n_state;
    logic [3:0]        r_c, n_c;
    logic [3:0]        r_r, n_r;
    logic [NODE_W-1:0] r_j, n_j;
    logic [ELEM_W-1:0] r_e, n_e;
    logic [5:0]        r_div, n_div;
    logic              r_train, n_train;

    logic [3:0]        w_clast;
    logic [3:0]        w_rlast;
    logic [ELEM_W-1:0] w_elast;
    logic              w_last_node;

    assign w_clast     = 4'(i_geom.width - 5'd1);
    assign w_rlast     = 4'(i_geom.height - 5'd1);
    assign w_elast     = ELEM_W'(i_geom.dim - 7'd1);
    assign w_last_node = (r_c == w_clast) && (r_r == w_rlast);

    // state and loop counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_c     <= '0;
            r_r     <= '0;
            r_j     <= '0;
            r_e     <= '0;
            r_div   <= '0;
            r_train <= 1'b0;
        end else begin
            r_state <= n_state;
            r_c     <= n_c;
            r_r     <= n_r;
            r_j     <= n_j;
            r_e     <= n_e;
            r_div   <= n_div;
            r_train <= n_train;
        end
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_c          = r_c;
        n_r          = r_r;
        n_j          = r_j;
        n_e          = r_e;
        n_div        = r_div;
        n_train      = r_train;
        o_item_ready = 1'b0;
        o_cmd        = '0;
        o_cmd.node   = r_j;
        o_cmd.elem   = r_e;
        o_cmd.col    = r_c;
        o_cmd.row    = r_r;

        case (r_state)
            ST_IDLE: begin
                o_item_ready = 1'b1;
                if (i_item_valid) begin
                    if (i_item_mode == MODE_LOAD) begin
                        o_cmd.w_load = 1'b1;
                    end else if (i_item_mode inside {MODE_TRAIN, MODE_CLASS}) begin
                        o_cmd.x_load = 1'b1;
                        if (i_item_last) begin
                            n_train         = (i_item_mode == MODE_TRAIN);
                            n_c             = '0;
                            n_r             = '0;
                            n_j             = '0;
                            n_e             = '0;
                            o_cmd.best_init = 1'b1;
                            o_cmd.cnt_clr   = 1'b1;
                            o_cmd.acc_clr   = 1'b1;
                            n_state         = ST_DRD;
                        end
                    end
                end
            end
            // distance pass: stream one node's elements
            ST_DRD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_dist = 1'b1;
                if (r_e == w_elast) begin
                    n_e     = '0;
                    n_state = ST_DW1;
                end else begin
                    n_e = r_e + 1'b1;
                end
            end
            ST_DW1: begin
                n_state = ST_DW2;
            end
            ST_DW2: begin
                n_state = ST_DCMP;
            end
            ST_DCMP: begin
                o_cmd.cmp     = 1'b1;
                o_cmd.acc_clr = 1'b1;
                if (w_last_node) begin
                    n_c     = '0;
                    n_r     = '0;
                    n_j     = '0;
                    n_state = r_train ? ST_RPREP : ST_FIN;
                end else begin
                    n_j = r_j + 1'b1;
                    if (r_c == w_clast) begin
                        n_c = '0;
                        n_r = r_r + 1'b1;
                    end else begin
                        n_c = r_c + 1'b1;
                    end
                    n_state = ST_DRD;
                end
            end
            // neighbourhood update
            ST_RPREP: begin
                o_cmd.rad_prep = 1'b1;
                n_state        = ST_RCHK;
            end
            ST_RCHK: begin
                o_cmd.rad_chk = 1'b1;
                n_state       = ST_RDEC;
            end
            ST_RDEC: begin
                if (i_stat.in_radius) begin
                    o_cmd.cnt_inc = 1'b1;
                    n_e           = '0;
                    n_state       = ST_URD;
                end else if (w_last_node) begin
                    o_cmd.step_inc = 1'b1;
                    n_state        = ST_FIN;
                end else begin
                    n_j = r_j + 1'b1;
                    if (r_c == w_clast) begin
                        n_c = '0;
                        n_r = r_r + 1'b1;
                    end else begin
                        n_c = r_c + 1'b1;
                    end
                    n_state = ST_RCHK;
                end
            end
            ST_URD: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ST_ULOAD;
            end
            ST_ULOAD: begin
                o_cmd.upd_load = 1'b1;
                n_div          = '0;
                n_state        = ST_UDIV;
            end
            ST_UDIV: begin
                o_cmd.div_step = 1'b1;
                if (r_div == 6'(DIV_STEPS - 1)) begin
                    n_state = ST_UWR;
                end else begin
                    n_div = r_div + 1'b1;
                end
            end
            ST_UWR: begin
                o_cmd.upd_wr = 1'b1;
                if (r_e != w_elast) begin
                    n_e     = r_e + 1'b1;
                    n_state = ST_URD;
                end else if (w_last_node) begin
                    o_cmd.step_inc = 1'b1;
                    n_state        = ST_FIN;
                end else begin
                    n_j = r_j + 1'b1;
                    if (r_c == w_clast) begin
                        n_c = '0;
                        n_r = r_r + 1'b1;
                    end else begin
                        n_c = r_c + 1'b1;
                    end
                    n_state = ST_RCHK;
                end
            end
            // hand the result to the output register
            ST_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

// ----- hw/rtl/som_dp.sv -----
`default_nettype none
module som_dp (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire som_pkg::t_cmd             i_cmd,
    input  wire logic [som_pkg::NODE_W-1:0] i_node_index,
    input  wire logic [som_pkg::ELEM_W-1:0] i_element_index,
    input  wire logic [31:0]               i_value,
    output som_pkg::t_stat                 o_stat,
    input  wire logic                      i_out_ready,
    output logic                           o_out_valid,
    output logic [7:0]                     o_winner_index,
    output logic [3:0]                     o_winner_col,
    output logic [3:0]                     o_winner_row,
    output logic [8:0]                     o_updated_count
);
    import som_pkg::*;

    logic [31:0]        w_wq, w_xq, w_new, w_wdata;
    logic [ADDR_W-1:0]  w_waddr;
    logic signed [32:0] w_diff;
    logic               w_neg;
    logic [31:0]        w_mag;
    logic [63:0]        w_sq;
    logic [64:0]        w_sum;
    logic [32:0]        w_s;
    logic [3:0]         w_dx, w_dy;
    logic [8:0]         w_dsq;
    logic [58:0]        w_prod;
    logic [49:0]        w_num;
    logic [33:0]        w_trial;
    logic               w_qbit;

    logic               r_p1_v, r_sq_v;
    logic [63:0]        r_sq, r_acc, r_best;
    logic [7:0]         r_win;
    logic [3:0]         r_wc, r_wr;
    logic [31:0]        r_t;
    logic               r_big;
    logic [49:0]        r_s2;
    logic [32:0]        r_den;
    logic               r_inrad;
    logic [31:0]        r_w;
    logic               r_neg;
    logic [32:0]        r_rem, r_quo;
    logic [8:0]         r_cnt;
    logic               r_out_v;

    // weight and input vector stores
    assign w_waddr = i_cmd.w_load ? {i_node_index, i_element_index} : {i_cmd.node, i_cmd.elem};
    assign w_wdata = i_cmd.w_load ? i_value : w_new;

    som_ram #(.WIDTH(32), .DEPTH(MAX_NODES * MAX_DIM)) u_wram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.w_load | i_cmd.upd_wr),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr ({i_cmd.node, i_cmd.elem}),
        .o_rdata (w_wq)
    );

    som_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_xram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.x_load),
        .i_waddr (i_element_index),
        .i_wdata (i_value),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_cmd.elem),
        .o_rdata (w_xq)
    );

    // element difference and square
    assign w_diff = $signed({w_xq[31], w_xq}) - $signed({w_wq[31], w_wq});
    assign w_neg  = w_diff[32];
    assign w_mag  = w_neg ? 32'(-w_diff) : w_diff[31:0];
    assign w_sq   = 64'(w_mag) * 64'(w_mag);
    assign w_sum  = {1'b0, r_acc} + {1'b0, r_sq};

    // neighbourhood test
    assign w_s    = {1'b0, r_t} + RADIUS_BASE;
    assign w_dx   = (i_cmd.col > r_wc) ? i_cmd.col - r_wc : r_wc - i_cmd.col;
    assign w_dy   = (i_cmd.row > r_wr) ? i_cmd.row - r_wr : r_wr - i_cmd.row;
    assign w_dsq  = 9'({4'b0, w_dx} * {4'b0, w_dx}) + 9'({4'b0, w_dy} * {4'b0, w_dy});
    assign w_prod = 59'(w_dsq) * 59'(r_s2);

    // rounded quotient numerator and one restoring step
    assign w_num   = 50'(w_mag) * 50'(RATE_BASE) + 50'(r_den >> 1);
    assign w_trial = {r_rem, r_quo[32]};
    assign w_qbit  = (w_trial >= {1'b0, r_den});
    assign w_new   = r_neg ? r_w - r_quo[31:0] : r_w + r_quo[31:0];

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v  <= 1'b0;
            r_sq_v  <= 1'b0;
            r_t     <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_p1_v <= i_cmd.rd_dist;
            r_sq_v <= r_p1_v;
            if (i_cmd.step_inc) begin
                r_t <= r_t + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // arithmetic registers
    always_ff @(posedge i_clk) begin
        r_sq <= w_sq;
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_sq_v) begin
            r_acc <= w_sum[64] ? '1 : w_sum[63:0];
        end
        if (i_cmd.best_init) begin
            r_best <= DIST_LIMIT;
            r_win  <= '0;
            r_wc   <= '0;
            r_wr   <= '0;
        end else if (i_cmd.cmp && (r_acc < r_best)) begin
            r_best <= r_acc;
            r_win  <= i_cmd.node;
            r_wc   <= i_cmd.col;
            r_wr   <= i_cmd.row;
        end
        if (i_cmd.rad_prep) begin
            r_big <= (w_s > S_MAX);
            r_s2  <= 50'(w_s[24:0]) * 50'(w_s[24:0]);
            r_den <= {1'b0, r_t} + 33'(RATE_BASE);
        end
        if (i_cmd.rad_chk) begin
            r_inrad <= (w_dsq == 9'd0) || (!r_big && (w_prod <= RADIUS_NUM));
        end
        if (i_cmd.upd_load) begin
            r_w   <= w_wq;
            r_neg <= w_neg;
            r_rem <= 33'(w_num[49:33]);
            r_quo <= w_num[32:0];
        end else if (i_cmd.div_step) begin
            r_rem <= w_qbit ? 33'(w_trial - {1'b0, r_den}) : w_trial[32:0];
            r_quo <= {r_quo[31:0], w_qbit};
        end
        if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.out_load) begin
            o_winner_index  <= r_win;
            o_winner_col    <= r_wc;
            o_winner_row    <= r_wr;
            o_updated_count <= r_cnt;
        end
    end

    assign o_out_valid      = r_out_v;
    assign o_stat.in_radius = r_inrad;
    assign o_stat.out_free  = !r_out_v || i_out_ready;
endmodule
`default_nettype wire
